// ----- rtl/core/hkrb_pkg.sv -----
package hkrb_pkg;

    // Number of key slots kept, and the number shown in a report
    localparam int KEY_SLOTS    = 6;
    localparam int REPORT_SLOTS = 6;

    // First modifier usage code (left control)
    localparam logic [7:0] MOD_FIRST = 8'hE0;

    // Operation codes of an input transaction
    typedef enum logic [2:0] {
        FUNC_PRESS_STD   = 3'd0,
        FUNC_RELEASE_STD = 3'd1,
        FUNC_PRESS_CON   = 3'd2,
        FUNC_RELEASE_CON = 3'd3,
        FUNC_CLEAR_STD   = 3'd4,
        FUNC_CLEAR_CON   = 3'd5,
        FUNC_SYNC        = 3'd6
    } t_func;

    // Report kinds
    localparam logic KIND_STD = 1'b0;
    localparam logic KIND_CON = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CON
    } t_state;

    // Input transaction
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] key_code;
    } t_item;

    // Result transaction
    typedef struct packed {
        logic       report_kind;
        logic [7:0] modifier_byte;
        logic [7:0] slot_zero;
        logic [7:0] slot_one;
        logic [7:0] slot_two;
        logic [7:0] slot_three;
        logic [7:0] slot_four;
        logic [7:0] slot_five;
        logic [7:0] consumer_byte;
        logic       last;
    } t_result;

    // Command broadcast to every slot cell
    typedef struct packed {
        logic       press;
        logic       release_key;
        logic       clear;
        logic [7:0] code;
    } t_cell_cmd;

    // Flags rippling from slot 0 toward the last slot
    typedef struct packed {
        logic free_seen;
        logic hit_seen;
        logic used_seen;
    } t_fwd;

    // Tail information rippling from the last slot toward slot 0
    typedef struct packed {
        logic       empty;
        logic [7:0] tail_val;
    } t_bwd;

    // Report data from the sequencer
    typedef struct packed {
        logic       valid;
        logic       kind;
        logic       last;
        logic [7:0] modifier;
        logic [7:0] consumer;
    } t_emit;

endpackage

// ----- rtl/core/hkrb_slot_cell.sv -----
module hkrb_slot_cell
    import hkrb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_fwd      i_fwd,
    output t_fwd      o_fwd,
    input  t_bwd      i_bwd,
    output t_bwd      o_bwd,
    output logic [7:0] o_slot
);

    logic [7:0] r_slot;
    logic [7:0] n_slot;
    logic       empty_here;
    logic       match_here;
    logic       is_tail;

    assign empty_here = (r_slot == 8'h00);
    assign match_here = (r_slot == i_cmd.code);
    // Slots stay packed, so the tail is the used slot with an empty right neighbor
    assign is_tail    = !empty_here && i_bwd.empty;

    // Pass flags to the right neighbor
    assign o_fwd.free_seen = i_fwd.free_seen | empty_here;
    assign o_fwd.hit_seen  = i_fwd.hit_seen | match_here;
    assign o_fwd.used_seen = i_fwd.used_seen | !empty_here;

    // Pass tail value to the left neighbor
    assign o_bwd.empty    = empty_here;
    assign o_bwd.tail_val = is_tail ? r_slot : i_bwd.tail_val;

    // Update this slot
    always_comb begin
        n_slot = r_slot;
        if (i_cmd.clear) begin
            n_slot = 8'h00;
        end else if (i_cmd.press) begin
            if (empty_here && !i_fwd.free_seen) begin
                n_slot = i_cmd.code;
            end
        end else if (i_cmd.release_key) begin
            if (match_here && !i_fwd.hit_seen) begin
                // first match: take the tail, or drop out if this is the tail
                n_slot = is_tail ? 8'h00 : i_bwd.tail_val;
            end else if (is_tail && i_fwd.hit_seen) begin
                // tail moved into an earlier matching slot
                n_slot = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= 8'h00;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

// ----- rtl/core/hkrb_ctrl.sv -----
module hkrb_ctrl
    import hkrb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_item     i_item,
    output logic      o_busy,
    input  t_fwd      i_sum,
    output t_cell_cmd o_cmd,
    output t_emit     o_emit
);

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_func;
    logic [7:0] r_code;
    logic [7:0] r_mod;
    logic [7:0] n_mod;
    logic [7:0] r_cons;
    logic [7:0] n_cons;
    logic       r_std_dirty;
    logic       n_std_dirty;
    logic       r_con_dirty;
    logic       n_con_dirty;
    logic       is_mod_code;
    logic [7:0] mod_off;
    logic [7:0] mod_mask;

    assign o_busy = (r_state != ST_IDLE);

    // Decode modifier usage codes
    assign mod_off     = r_code - MOD_FIRST;
    assign is_mod_code = (r_code >= MOD_FIRST);
    assign mod_mask    = (mod_off[7:3] == 5'd0) ? (8'h01 << mod_off[2:0]) : 8'h00;

    // Capture the transaction
    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_func <= i_item.func;
            r_code <= i_item.key_code;
        end
    end

    // Hold state and report registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mod       <= 8'h00;
            r_cons      <= 8'h00;
            r_std_dirty <= 1'b0;
            r_con_dirty <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mod       <= n_mod;
            r_cons      <= n_cons;
            r_std_dirty <= n_std_dirty;
            r_con_dirty <= n_con_dirty;
        end
    end

    // Execute one operation, sequence sync reports
    always_comb begin
        n_state     = r_state;
        n_mod       = r_mod;
        n_cons      = r_cons;
        n_std_dirty = r_std_dirty;
        n_con_dirty = r_con_dirty;
        o_cmd       = '0;
        o_cmd.code  = r_code;
        o_emit      = '0;
        o_emit.modifier = r_mod;
        o_emit.consumer = r_cons;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                case (t_func'(r_func))
                    FUNC_PRESS_STD: begin
                        if (is_mod_code) begin
                            n_mod       = r_mod | mod_mask;
                            n_std_dirty = 1'b1;
                        end else begin
                            o_cmd.press = 1'b1;
                            if (i_sum.free_seen) begin
                                n_std_dirty = 1'b1;
                            end
                        end
                    end
                    FUNC_RELEASE_STD: begin
                        if (is_mod_code) begin
                            n_mod       = r_mod & ~mod_mask;
                            n_std_dirty = 1'b1;
                        end else begin
                            o_cmd.release_key = 1'b1;
                            if (i_sum.hit_seen) begin
                                n_std_dirty = 1'b1;
                            end
                        end
                    end
                    FUNC_PRESS_CON: begin
                        n_cons      = r_cons | r_code;
                        n_con_dirty = 1'b1;
                    end
                    FUNC_RELEASE_CON: begin
                        n_cons      = r_cons & ~r_code;
                        n_con_dirty = 1'b1;
                    end
                    FUNC_CLEAR_STD: begin
                        if ((r_mod != 8'h00) || i_sum.used_seen) begin
                            o_cmd.clear = 1'b1;
                            n_mod       = 8'h00;
                            n_std_dirty = 1'b1;
                        end
                    end
                    FUNC_CLEAR_CON: begin
                        if (r_cons != 8'h00) begin
                            n_cons      = 8'h00;
                            n_con_dirty = 1'b1;
                        end
                    end
                    FUNC_SYNC: begin
                        if (r_std_dirty) begin
                            o_emit.valid = 1'b1;
                            o_emit.kind  = KIND_STD;
                            o_emit.last  = !r_con_dirty;
                            n_std_dirty  = 1'b0;
                            if (r_con_dirty) begin
                                n_state = ST_CON;
                            end
                        end else if (r_con_dirty) begin
                            o_emit.valid = 1'b1;
                            o_emit.kind  = KIND_CON;
                            o_emit.last  = 1'b1;
                            n_con_dirty  = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_CON: begin
                o_emit.valid = 1'b1;
                o_emit.kind  = KIND_CON;
                o_emit.last  = 1'b1;
                n_con_dirty  = 1'b0;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A consumer report always closes its sync
    a_con_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.valid && o_emit.kind == KIND_CON) |-> o_emit.last)
        else $error("consumer report not marked last");

    // The second report of a sync follows a standard report that was not last
    a_con_after_std: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CON) |-> $past(o_emit.valid && o_emit.kind == KIND_STD && !o_emit.last))
        else $error("consumer stage entered without a preceding standard report");

    // Nothing follows the last report of a sync
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.valid && o_emit.last) |=> !o_emit.valid)
        else $error("report emitted after last");

    // Slot cells only act during execution
    a_cmd_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.press || o_cmd.release_key || o_cmd.clear) |-> (r_state == ST_EXEC))
        else $error("slot command outside execution");
`endif

endmodule

// ----- rtl/core/hid_keyboard_report_builder.sv -----
// A transaction is accepted at a clock edge and executes in the next cycle; a sync
// that emits both reports shows its standard report in that cycle and its consumer
// report in the cycle after. No new transaction is accepted while busy, so the block
// takes the next one only once the sequencer, which drives the slot cell row, is idle.
// Reset (synchronous, active low) clears all reports, slots and dirty flags.
// Results are strobed for one cycle; the receiver cannot stall.
module hid_keyboard_report_builder
    import hkrb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_valid,
    output t_result o_result
);

    t_cell_cmd  cmd;
    t_emit      emit;
    t_fwd       fwd [KEY_SLOTS+1];
    t_bwd       bwd [KEY_SLOTS+1];
    logic [7:0] slot_q [KEY_SLOTS];
    logic [7:0] shown [REPORT_SLOTS];

    hkrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .o_busy  (busy),
        .i_sum   (fwd[KEY_SLOTS]),
        .o_cmd   (cmd),
        .o_emit  (emit)
    );

    // Chain ends
    assign fwd[0]                  = '0;
    assign bwd[KEY_SLOTS].empty    = 1'b1;
    assign bwd[KEY_SLOTS].tail_val = 8'h00;

    // Row of slot cells
    for (genvar gi = 0; gi < KEY_SLOTS; gi++) begin : g_cell
        hkrb_slot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_fwd   (fwd[gi]),
            .o_fwd   (fwd[gi+1]),
            .i_bwd   (bwd[gi+1]),
            .o_bwd   (bwd[gi]),
            .o_slot  (slot_q[gi])
        );
    end

    // Slots shown in a standard report; missing slots read zero
    for (genvar gr = 0; gr < REPORT_SLOTS; gr++) begin : g_show
        if (gr < KEY_SLOTS) begin : g_have
            assign shown[gr] = (emit.kind == KIND_STD) ? slot_q[gr] : 8'h00;
        end else begin : g_none
            assign shown[gr] = 8'h00;
        end
    end

    // Assemble the result transaction
    assign o_valid                = emit.valid;
    assign o_result.report_kind   = emit.kind;
    assign o_result.modifier_byte = (emit.kind == KIND_STD) ? emit.modifier : 8'h00;
    assign o_result.slot_zero     = shown[0];
    assign o_result.slot_one      = shown[1];
    assign o_result.slot_two      = shown[2];
    assign o_result.slot_three    = shown[3];
    assign o_result.slot_four     = shown[4];
    assign o_result.slot_five     = shown[5];
    assign o_result.consumer_byte = (emit.kind == KIND_CON) ? emit.consumer : 8'h00;
    assign o_result.last          = emit.last;

endmodule

// ----- tb/sv/hid_keyboard_report_builder_test.sv -----
module hid_keyboard_report_builder_test;
    import hkrb_pkg::*;

    localparam int          DIRECTED_STEPS = 28;
    localparam int          RANDOM_EVENTS  = 750;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT    = 100000;
    localparam logic [2:0]  FUNC_UNUSED    = 3'd7;
    localparam logic [7:0]  LAST_MOD       = 8'hE7;
    localparam logic [7:0]  FIRST_KEY      = 8'h04;
    localparam logic [7:0]  NARROW_KEY_END = 8'h1D;

    typedef struct {
        t_item   item;
        bit      fixed;
        t_result want;
    } t_script_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    // Mirror of the report state
    logic [7:0] held_mods;
    logic [7:0] held_keys [KEY_SLOTS];
    logic [7:0] held_consumer;
    bit         std_pending;
    bit         con_pending;

    t_result     pending_reports [$];
    t_script_row steps [DIRECTED_STEPS];

    int          mismatches      = 0;
    int          events_sent     = 0;
    int          reports_checked = 0;
    int          dual_syncs      = 0;
    int          presses_dropped = 0;
    int unsigned cycle_count     = 0;

    hid_keyboard_report_builder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Directed row whose reports come from the predictor
    function automatic t_script_row op(logic [2:0] f, logic [7:0] c);
        t_script_row r;
        r.item.func     = f;
        r.item.key_code = c;
        r.fixed         = 1'b0;
        r.want          = '0;
        return r;
    endfunction

    // Directed sync with a single standard report typed in
    function automatic t_script_row std_sync(logic [7:0] m, logic [7:0] s0, logic [7:0] s1,
                                             logic [7:0] s2, logic [7:0] s3, logic [7:0] s4,
                                             logic [7:0] s5);
        t_script_row r;
        r                    = op(FUNC_SYNC, 8'h00);
        r.fixed              = 1'b1;
        r.want.report_kind   = KIND_STD;
        r.want.modifier_byte = m;
        r.want.slot_zero     = s0;
        r.want.slot_one      = s1;
        r.want.slot_two      = s2;
        r.want.slot_three    = s3;
        r.want.slot_four     = s4;
        r.want.slot_five     = s5;
        r.want.last          = 1'b1;
        return r;
    endfunction

    // Update the mirrored reports for one operation and queue the reports it emits
    function automatic void apply_key_event(t_item it);
        int         hit;
        int         tail;
        int         n;
        bit         any;
        t_result    out [2];
        logic [7:0] code;
        code = it.key_code;
        n    = 0;
        case (it.func)
            FUNC_PRESS_STD: begin
                if (code >= MOD_FIRST) begin
                    if (code <= LAST_MOD) held_mods[code[2:0]] = 1'b1;
                    std_pending = 1'b1;
                end else begin
                    hit = -1;
                    for (int i = 0; i < KEY_SLOTS; i++)
                        if (hit < 0 && held_keys[i] == 8'h00) hit = i;
                    if (hit >= 0) begin
                        held_keys[hit] = code;
                        std_pending    = 1'b1;
                    end else begin
                        presses_dropped++;
                    end
                end
            end
            FUNC_RELEASE_STD: begin
                if (code >= MOD_FIRST) begin
                    if (code <= LAST_MOD) held_mods[code[2:0]] = 1'b0;
                    std_pending = 1'b1;
                end else begin
                    hit = -1;
                    for (int i = 0; i < KEY_SLOTS; i++)
                        if (hit < 0 && held_keys[i] == code) hit = i;
                    if (hit >= 0) begin
                        // Move the last used slot into the hole, then clear it
                        tail = KEY_SLOTS - 1;
                        while (tail > hit && held_keys[tail] == 8'h00) tail--;
                        held_keys[hit]  = held_keys[tail];
                        held_keys[tail] = 8'h00;
                        std_pending     = 1'b1;
                    end
                end
            end
            FUNC_PRESS_CON: begin
                held_consumer = held_consumer | code;
                con_pending   = 1'b1;
            end
            FUNC_RELEASE_CON: begin
                held_consumer = held_consumer & ~code;
                con_pending   = 1'b1;
            end
            FUNC_CLEAR_STD: begin
                any = (held_mods != 8'h00);
                for (int i = 0; i < KEY_SLOTS; i++)
                    if (held_keys[i] != 8'h00) any = 1'b1;
                if (any) begin
                    held_mods = 8'h00;
                    for (int i = 0; i < KEY_SLOTS; i++) held_keys[i] = 8'h00;
                    std_pending = 1'b1;
                end
            end
            FUNC_CLEAR_CON: begin
                if (held_consumer != 8'h00) begin
                    held_consumer = 8'h00;
                    con_pending   = 1'b1;
                end
            end
            FUNC_SYNC: begin
                if (std_pending) begin
                    out[n]               = '0;
                    out[n].report_kind   = KIND_STD;
                    out[n].modifier_byte = held_mods;
                    out[n].slot_zero     = held_keys[0];
                    out[n].slot_one      = held_keys[1];
                    out[n].slot_two      = held_keys[2];
                    out[n].slot_three    = held_keys[3];
                    out[n].slot_four     = held_keys[4];
                    out[n].slot_five     = held_keys[5];
                    std_pending          = 1'b0;
                    n++;
                end
                if (con_pending) begin
                    out[n]               = '0;
                    out[n].report_kind   = KIND_CON;
                    out[n].consumer_byte = held_consumer;
                    con_pending          = 1'b0;
                    n++;
                end
                if (n > 0) out[n-1].last = 1'b1;
                for (int i = 0; i < n; i++) pending_reports.push_back(out[i]);
                if (n == 2) dual_syncs++;
            end
            default: ;
        endcase
    endfunction

    // Draw one operation; releases are biased toward keys that are actually held
    function automatic t_item random_key_event();
        t_item it;
        int    roll;
        int    sel;
        roll        = $urandom_range(0, 99);
        sel         = $urandom_range(0, 99);
        it.key_code = 8'($urandom_range(0, 255));
        if (roll < 30) begin
            it.func = FUNC_PRESS_STD;
            if (sel < 70)      it.key_code = 8'($urandom_range(FIRST_KEY, NARROW_KEY_END));
            else if (sel < 84) it.key_code = 8'($urandom_range(MOD_FIRST, LAST_MOD));
            else if (sel < 90) it.key_code = 8'($urandom_range(LAST_MOD + 1, 8'hFF));
        end else if (roll < 55) begin
            it.func = FUNC_RELEASE_STD;
            if (sel < 55)      it.key_code = held_keys[$urandom_range(0, KEY_SLOTS - 1)];
            else if (sel < 70) it.key_code = 8'($urandom_range(MOD_FIRST, LAST_MOD));
            else if (sel < 85) it.key_code = 8'($urandom_range(FIRST_KEY, NARROW_KEY_END));
        end else if (roll < 64) begin
            it.func = FUNC_PRESS_CON;
        end else if (roll < 72) begin
            it.func = FUNC_RELEASE_CON;
        end else if (roll < 76) begin
            it.func = FUNC_CLEAR_STD;
        end else if (roll < 79) begin
            it.func = FUNC_CLEAR_CON;
        end else if (roll < 97) begin
            it.func = FUNC_SYNC;
        end else begin
            it.func = FUNC_UNUSED;
        end
        return it;
    endfunction

    // Hold one transaction until accepted, then predict its reports
    task automatic issue(t_item it, bit fixed, t_result want);
        int before_n;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        before_n = pending_reports.size();
        apply_key_event(it);
        if (fixed) begin
            while (pending_reports.size() > before_n) void'(pending_reports.pop_back());
            pending_reports.push_back(want);
        end
        events_sent++;
    endtask

    // Drop start and wait until every expected report has arrived
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    function automatic void field_check(string name, logic [7:0] exp, logic [7:0] act);
        if (act !== exp) begin
            $display("%0t: %s mismatch: expected %02h, got %02h", $time, name, exp, act);
            mismatches++;
        end
    endfunction

    // Compare each strobed report with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report: expected none, got %p", $time, o_result);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                field_check("report_kind",   8'(want.report_kind), 8'(o_result.report_kind));
                field_check("modifier_byte", want.modifier_byte, o_result.modifier_byte);
                field_check("slot_zero",     want.slot_zero,     o_result.slot_zero);
                field_check("slot_one",      want.slot_one,      o_result.slot_one);
                field_check("slot_two",      want.slot_two,      o_result.slot_two);
                field_check("slot_three",    want.slot_three,    o_result.slot_three);
                field_check("slot_four",     want.slot_four,     o_result.slot_four);
                field_check("slot_five",     want.slot_five,     o_result.slot_five);
                field_check("consumer_byte", want.consumer_byte, o_result.consumer_byte);
                field_check("last",          8'(want.last),      8'(o_result.last));
                reports_checked++;
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d reports outstanding", $time, pending_reports.size());
            $display("** hid_keyboard_report_builder: FAILED **");
            $finish;
        end
    end

    initial begin
        int    burst_left;
        int    gap;
        int    random_done;
        bit    mid_drained;
        t_item ev;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_item        <= '0;
        held_mods     = 8'h00;
        held_consumer = 8'h00;
        std_pending   = 1'b0;
        con_pending   = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) held_keys[i] = 8'h00;
        random_done = 0;
        burst_left  = 0;
        mid_drained = 1'b0;

        steps = '{
            op(FUNC_SYNC,        8'h00),  // nothing dirty after reset
            op(FUNC_PRESS_STD,   8'h04),
            op(FUNC_PRESS_STD,   8'hE0),  // lowest modifier
            op(FUNC_PRESS_STD,   8'hE7),  // highest modifier
            std_sync(8'h81, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
            op(FUNC_PRESS_STD,   8'hE8),  // reserved code still marks dirty
            std_sync(8'h81, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
            op(FUNC_PRESS_STD,   8'h05),
            op(FUNC_PRESS_STD,   8'h06),
            op(FUNC_PRESS_STD,   8'h07),
            op(FUNC_PRESS_STD,   8'h08),
            op(FUNC_PRESS_STD,   8'h09),
            op(FUNC_PRESS_STD,   8'h0A),  // slots full, dropped
            std_sync(8'h81, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09),
            op(FUNC_RELEASE_STD, 8'h05),  // tail slot moves into the hole
            op(FUNC_RELEASE_STD, 8'h33),  // not held
            op(FUNC_RELEASE_STD, 8'hE0),
            op(FUNC_PRESS_CON,   8'hFF),
            op(FUNC_RELEASE_CON, 8'h0F),
            op(FUNC_SYNC,        8'h00),  // both reports
            op(FUNC_PRESS_STD,   8'h00),  // code zero into a free slot
            op(FUNC_RELEASE_STD, 8'hFF),
            op(FUNC_CLEAR_STD,   8'h00),
            op(FUNC_CLEAR_CON,   8'h00),
            op(FUNC_UNUSED,      8'h5A),  // ignored
            op(FUNC_SYNC,        8'h00),
            op(FUNC_CLEAR_STD,   8'hFF),  // already empty
            op(FUNC_SYNC,        8'h00)
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table with occasional gaps
        foreach (steps[k]) begin
            issue(steps[k].item, steps[k].fixed, steps[k].want);
            if ($urandom_range(0, 2) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
        drain();

        // Random operations in bursts; stop once halfway until idle
        while (random_done < RANDOM_EVENTS) begin
            if (!mid_drained && random_done >= RANDOM_EVENTS / 2) begin
                drain();
                mid_drained = 1'b1;
                burst_left  = 0;
            end
            if (burst_left <= 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    burst_left = 60;
                    gap        = 0;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap        = $urandom_range(0, 7);
                end
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            ev = random_key_event();
            issue(ev, 1'b0, '0);
            if (ev.func != FUNC_UNUSED) random_done++;
            burst_left--;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            $display("%0t: %0d expected reports never arrived", $time, pending_reports.size());
            mismatches++;
        end

        $display("Ran %0d operations (%0d from the directed table), checked %0d reports.",
                 events_sent, DIRECTED_STEPS, reports_checked);
        $display("Syncs emitting both reports: %0d, presses dropped on full slots: %0d.",
                 dual_syncs, presses_dropped);
        if (mismatches == 0) begin
            $display("** hid_keyboard_report_builder: PASSED **");
        end else begin
            $display("** hid_keyboard_report_builder: FAILED **");
        end
        $finish;
    end

endmodule
